// File: sv/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths and helpers for the vector normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package vn_pkg;
   localparam int LANES = 3;

   function automatic int bytes_up(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction
endpackage
`default_nettype wire

// File: sv/vn_square.sv
// ----------------------------------------------------------------------------
// vn_square
// Front end: component magnitudes and squares, then the sum of squares and
// the per-lane search bound, two elastic stages.
// ----------------------------------------------------------------------------
`default_nettype none
module vn_square import vn_pkg::*; #(
   parameter int IN_BITS   = 16,
   parameter int FRAC_BITS = 14,
   parameter int SW        = 2 * IN_BITS,
   parameter int PW        = 2 * IN_BITS + 2 * FRAC_BITS + 4
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  wire  [IN_BITS-1:0]        in_comp [LANES],
   output logic                      out_valid,
   input  wire                       out_ready,
   output logic [SW-1:0]             out_s,
   output logic                      out_zero,
   output logic                      out_neg [LANES],
   output logic signed [PW-1:0]      out_p [LANES],
   output logic signed [PW-1:0]      out_sd [LANES],
   output logic signed [PW-1:0]      out_r [LANES]
);
   localparam int QW = 2 * IN_BITS - 1;

   logic            v1_ff, v1_in, v2_ff, v2_in;
   logic            rdy1, rdy2;
   logic [QW-1:0]   sq_ff [LANES];
   logic [QW-1:0]   sq_in [LANES];
   logic            neg1_ff [LANES];
   logic            neg1_in [LANES];
   logic [SW-1:0]   s_in;
   logic            zero_in;
   logic signed [PW-1:0] r_in [LANES];
   logic [IN_BITS-1:0]   mag [LANES];

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign v1_in    = rdy1 ? in_valid : v1_ff;
   assign v2_in    = rdy2 ? v1_ff : v2_ff;
   assign out_valid = v2_ff;

   always_comb begin
      s_in = '0;
      for (int i = 0; i < LANES; i++) begin
         neg1_in[i] = in_comp[i][IN_BITS-1];
         mag[i]     = neg1_in[i] ? (~in_comp[i] + 1'b1) : in_comp[i];
         sq_in[i]   = QW'(mag[i]) * QW'(mag[i]);
         s_in       = s_in + SW'(sq_ff[i]);
         r_in[i]    = $signed(PW'(sq_ff[i]) << (2 * FRAC_BITS + 2));
      end
      zero_in = (s_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (rdy1) begin
         sq_ff   <= sq_in;
         neg1_ff <= neg1_in;
      end
      if (rdy2) begin
         out_s    <= s_in;
         out_zero <= zero_in;
         for (int i = 0; i < LANES; i++) begin
            out_neg[i] <= neg1_ff[i];
            out_r[i]   <= r_in[i];
            out_p[i]   <= $signed(PW'(s_in));
            out_sd[i]  <= -$signed(PW'(s_in));
         end
      end
   end
endmodule
`default_nettype wire

// File: sv/vn_cell.sv
// ----------------------------------------------------------------------------
// vn_cell
// One quotient bit per cell, all three lanes: try setting bit BIT of q and
// keep it if q's top bit is clear and (2q-1)^2*s <= bound. Shift-and-add only.
// ----------------------------------------------------------------------------
`default_nettype none
module vn_cell import vn_pkg::*; #(
   parameter int IN_BITS   = 16,
   parameter int FRAC_BITS = 14,
   parameter int BIT       = 14,
   parameter int SW        = 2 * IN_BITS,
   parameter int PW        = 2 * IN_BITS + 2 * FRAC_BITS + 4
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  wire  [SW-1:0]             in_s,
   input  wire                       in_zero,
   input  wire                       in_neg [LANES],
   input  wire  [FRAC_BITS:0]        in_q [LANES],
   input  wire  signed [PW-1:0]      in_p [LANES],
   input  wire  signed [PW-1:0]      in_sd [LANES],
   input  wire  signed [PW-1:0]      in_r [LANES],
   output logic                      out_valid,
   input  wire                       out_ready,
   output logic [SW-1:0]             out_s,
   output logic                      out_zero,
   output logic                      out_neg [LANES],
   output logic [FRAC_BITS:0]        out_q [LANES],
   output logic signed [PW-1:0]      out_p [LANES],
   output logic signed [PW-1:0]      out_sd [LANES],
   output logic signed [PW-1:0]      out_r [LANES]
);
   logic                 v_ff, v_in, rdy;
   logic signed [PW-1:0] s_x;
   logic signed [PW-1:0] p_try [LANES];
   logic [FRAC_BITS:0]   q_in [LANES];
   logic signed [PW-1:0] p_in [LANES];
   logic signed [PW-1:0] sd_in [LANES];
   logic                 take [LANES];

   assign rdy       = !v_ff || out_ready;
   assign in_ready  = rdy;
   assign v_in      = rdy ? in_valid : v_ff;
   assign out_valid = v_ff;

   always_comb begin
      s_x = $signed(PW'(in_s));
      for (int i = 0; i < LANES; i++) begin
         p_try[i] = in_p[i] + (in_sd[i] <<< (BIT + 2)) + (s_x <<< (2 * BIT + 2));
         take[i]  = !in_q[i][FRAC_BITS] && (p_try[i] <= in_r[i]);
         q_in[i]  = take[i] ? (in_q[i] | ((FRAC_BITS + 1)'(1) << BIT)) : in_q[i];
         p_in[i]  = take[i] ? p_try[i] : in_p[i];
         sd_in[i] = take[i] ? (in_sd[i] + (s_x <<< (BIT + 1))) : in_sd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (rdy) begin
         out_s    <= in_s;
         out_zero <= in_zero;
         out_neg  <= in_neg;
         out_q    <= q_in;
         out_p    <= p_in;
         out_sd   <= sd_in;
         out_r    <= in_r;
      end
   end
endmodule
`default_nettype wire

// File: sv/vector3_normalizer_top.sv
// ----------------------------------------------------------------------------
// vector3_normalizer_top
// Unit vector of a signed three-component vector, Q1.FRAC_BITS, rounded.
// ----------------------------------------------------------------------------
// One vector per clock when the result side does not stall. Stages: two
// front stages (squares, then sum), one cell per quotient bit (FRAC_BITS+1
// cells, each a shift-add and compare), and the output register. Every stage
// is elastic, so bubbles collapse while the result side stalls.
`default_nettype none
module vector3_normalizer_top import vn_pkg::*; #(
   parameter int IN_BITS   = 16,
   parameter int FRAC_BITS = 14
) (
   input  wire  clock,
   input  wire  reset,
   input  wire  req_tvalid,
   output logic req_tready,
   // comp_x, comp_y, comp_z, zero pad
   input  wire  [bytes_up(3 * IN_BITS)-1:0] req_tdata,
   output logic rsp_tvalid,
   input  wire  rsp_tready,
   // unit_x, unit_y, unit_z, zero pad
   output logic [bytes_up(3 * (FRAC_BITS + 2))-1:0] rsp_tdata,
   // was_zero
   output logic rsp_tuser
);
   localparam int SW  = 2 * IN_BITS;
   localparam int PW  = 2 * IN_BITS + 2 * FRAC_BITS + 4;
   localparam int OW  = FRAC_BITS + 2;
   localparam int NC  = FRAC_BITS + 1;
   localparam int ODW = bytes_up(3 * OW);

   logic [IN_BITS-1:0]   comp [LANES];
   logic                 c_valid [NC+1];
   logic                 c_ready [NC+1];
   logic [SW-1:0]        c_s [NC+1];
   logic                 c_zero [NC+1];
   logic                 c_neg [NC+1][LANES];
   logic [FRAC_BITS:0]   c_q [NC+1][LANES];
   logic signed [PW-1:0] c_p [NC+1][LANES];
   logic signed [PW-1:0] c_sd [NC+1][LANES];
   logic signed [PW-1:0] c_r [NC+1][LANES];
   logic                 vo_ff, vo_in, rdy_o;
   logic [OW-1:0]        u_ff [LANES];
   logic [OW-1:0]        u_in [LANES];
   logic                 z_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         comp[i] = req_tdata[i*IN_BITS +: IN_BITS];
      end
   end

   assign c_q[0] = '{default: '0};

   vn_square #(.IN_BITS(IN_BITS), .FRAC_BITS(FRAC_BITS), .SW(SW), .PW(PW)) u_square (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_comp(comp),
      .out_valid(c_valid[0]), .out_ready(c_ready[0]),
      .out_s(c_s[0]), .out_zero(c_zero[0]), .out_neg(c_neg[0]),
      .out_p(c_p[0]), .out_sd(c_sd[0]), .out_r(c_r[0])
   );

   for (genvar k = 0; k < NC; k++) begin : g_cell
      vn_cell #(.IN_BITS(IN_BITS), .FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - k),
                .SW(SW), .PW(PW)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(c_valid[k]), .in_ready(c_ready[k]),
         .in_s(c_s[k]), .in_zero(c_zero[k]), .in_neg(c_neg[k]), .in_q(c_q[k]),
         .in_p(c_p[k]), .in_sd(c_sd[k]), .in_r(c_r[k]),
         .out_valid(c_valid[k+1]), .out_ready(c_ready[k+1]),
         .out_s(c_s[k+1]), .out_zero(c_zero[k+1]), .out_neg(c_neg[k+1]),
         .out_q(c_q[k+1]), .out_p(c_p[k+1]), .out_sd(c_sd[k+1]), .out_r(c_r[k+1])
      );
   end

   assign rdy_o       = !vo_ff || rsp_tready;
   assign c_ready[NC] = rdy_o;
   assign vo_in       = rdy_o ? c_valid[NC] : vo_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (c_zero[NC]) begin
            u_in[i] = '0;
         end else if (c_neg[NC][i]) begin
            u_in[i] = -OW'(c_q[NC][i]);
         end else begin
            u_in[i] = OW'(c_q[NC][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= vo_in;
      end
      if (rdy_o) begin
         u_ff <= u_in;
         z_ff <= c_zero[NC];
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tuser  = z_ff;
   assign rsp_tdata  = ODW'({u_ff[2], u_ff[1], u_ff[0]});
endmodule
`default_nettype wire

// File: sv/vector3_normalizer_checker.sv
// ----------------------------------------------------------------------------
// vector3_normalizer_checker
// Port-level checks for the vector normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module vector3_normalizer_checker import vn_pkg::*; #(
   parameter int IN_BITS   = 16,
   parameter int FRAC_BITS = 14
) (
   input wire clock,
   input wire reset,
   input wire req_tvalid,
   input wire req_tready,
   input wire rsp_tvalid,
   input wire rsp_tready,
   input wire [bytes_up(3 * (FRAC_BITS + 2))-1:0] rsp_tdata,
   input wire rsp_tuser
);
   localparam int OW = FRAC_BITS + 2;
   localparam logic signed [OW-1:0] ONE  = OW'(1) << FRAC_BITS;

   logic signed [OW-1:0] ux, uy, uz;
   assign ux = rsp_tdata[0 +: OW];
   assign uy = rsp_tdata[OW +: OW];
   assign uz = rsp_tdata[2*OW +: OW];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> ux == '0 && uy == '0 && uz == '0)
      else $error("zero vector gave nonzero components");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ux <= ONE && ux >= -ONE && uy <= ONE && uy >= -ONE
                     && uz <= ONE && uz >= -ONE)
      else $error("component outside unit range");

   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

bind vector3_normalizer_top vector3_normalizer_checker #(
   .IN_BITS(IN_BITS), .FRAC_BITS(FRAC_BITS)
) u_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
`default_nettype wire
